@@ sv/cfpd_pkg.sv @@
// Shared types and constants for the CAN frame packet deframer.
`default_nettype none
package cfpd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W = 6;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned RESULT_W = 147;
  localparam int unsigned OUT_TDATA_W = 152;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LENGTH  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_START   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TYPE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LENBYTE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CHECK   = 3'd5;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_ONE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_TWO = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TYPE      = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] start_one;
    logic [BYTE_W-1:0] start_two;
    logic [BYTE_W-1:0] wanted_type;
  } cfg_t;

  // Packed lowest field last so status lands in the low bits.
  typedef struct packed {
    logic [63:0]         frame_data;
    logic [7:0]          frame_flags;
    logic [7:0]          length_code;
    logic [31:0]         frame_id;
    logic [31:0]         timestamp;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage
`default_nettype wire

@@ sv/can_frame_packet_deframer_top.sv @@
// Top level of the CAN frame packet deframer.
//
// Received packet bytes enter on the slave stream, one byte per request in
// s_tdata, with s_tlast on the last byte of a packet. Each packet gives one
// result request on the master stream when its last byte is processed; other
// bytes give none. The result carries a status (0 ok, 1 length, 2 start byte,
// 3 type, 4 length byte, 5 checksum) and, for a good packet, the captured
// timestamp, identifier, length code, flags and data bytes (zero otherwise).
// Start bytes and expected type are set over the cfg channel; the user must
// set them only while idle, which the block does not enforce. A byte is taken
// every cycle while s_tready is high: it passes the input register and the
// check/capture logic into the result register, which drives m_tvalid. If
// m_tready stays low, one result waits there while data bytes keep flowing;
// the next last byte waits in the input register and s_tready then drops.
// Reset clears the packet state and restores the start bytes to 0xAA and
// 0x55 and the expected type to 0; no clearing pass is needed.
`default_nettype none
module can_frame_packet_deframer_top
  import cfpd_pkg::*;
#(
  parameter int unsigned DATA_BYTES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
  input  wire logic                   s_tlast,   // end_of_packet
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [2:0] status, [34:3] timestamp, [66:35] frame_id, [74:67] length_code,
  // [82:75] frame_flags, [146:83] frame_data, [151:147] zero
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]      cfg_data
);

  cfg_t cfg;

  logic              q_valid;
  logic [BYTE_W-1:0] q_byte;
  logic              q_last;
  logic              q_take;
  logic              res_ready;
  logic              res_load;
  result_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_one   <= 8'hAA;
      cfg.start_two   <= 8'h55;
      cfg.wanted_type <= 8'h00;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_ONE: cfg.start_one   <= cfg_data;
        CFG_START_TWO: cfg.start_two   <= cfg_data;
        CFG_TYPE:      cfg.wanted_type <= cfg_data;
        default:       cfg <= cfg;
      endcase
    end
  end

  cfpd_in_slice u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_byte   (q_byte),
    .q_last   (q_last),
    .q_take   (q_take)
  );

  cfpd_parse #(
    .DATA_BYTES (DATA_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (q_valid),
    .in_byte   (q_byte),
    .in_last   (q_last),
    .in_take   (q_take),
    .res_ready (res_ready),
    .res_load  (res_load),
    .res       (res)
  );

  cfpd_out_slice u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (res_load),
    .res        (res),
    .load_ready (res_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
`default_nettype wire

@@ sv/cfpd_in_slice.sv @@
// Input register for received bytes.
`default_nettype none
module cfpd_in_slice
  import cfpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [BYTE_W-1:0] s_tdata,
  input  wire logic              s_tlast,
  output logic                   q_valid,
  output logic [BYTE_W-1:0]      q_byte,
  output logic                   q_last,
  input  wire logic              q_take
);

  assign s_tready = !q_valid || q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_tready) begin
      q_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      q_byte <= s_tdata;
      q_last <= s_tlast;
    end
  end

endmodule
`default_nettype wire

@@ sv/cfpd_parse.sv @@
// Per-byte packet checks, checksum and field capture.
`default_nettype none
module cfpd_parse
  import cfpd_pkg::*;
#(
  parameter int unsigned DATA_BYTES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_last,
  output logic                   in_take,
  input  wire logic              res_ready,
  output logic                   res_load,
  output result_t                res
);

  localparam int unsigned BODY_LEN = 10 + DATA_BYTES;
  localparam int unsigned FULL_LEN = BODY_LEN + 5;
  localparam logic [BYTE_W-1:0] BODY_LEN_BYTE = BYTE_W'(BODY_LEN);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FULL_LEN - 1);
  localparam logic [POS_W-1:0] XOR_END = POS_W'(FULL_LEN - 2);
  localparam logic [POS_W-1:0] DATA_END = POS_W'(14 + DATA_BYTES);

  logic [POS_W-1:0]    byte_position;
  logic [BYTE_W-1:0]   running_xor;
  logic [STATUS_W-1:0] first_error;
  logic [31:0]         captured_time;
  logic [31:0]         captured_id;
  logic [7:0]          captured_dlc;
  logic [7:0]          captured_flags;
  logic [63:0]         captured_payload;

  logic [STATUS_W-1:0] error_next;
  logic [POS_W-1:0]    data_offset;
  logic [STATUS_W-1:0] status;

  assign in_take  = in_valid && (!in_last || res_ready);
  assign res_load = in_take && in_last;
  assign data_offset = byte_position - POS_W'(14);

  always_comb begin
    error_next = first_error;
    if (first_error == ST_OK) begin
      case (byte_position)
        POS_W'(0): if (in_byte != cfg.start_one) error_next = ST_START;
        POS_W'(1): if (in_byte != cfg.start_two) error_next = ST_START;
        POS_W'(2): if (in_byte != cfg.wanted_type) error_next = ST_TYPE;
        POS_W'(3): if (in_byte != BODY_LEN_BYTE) error_next = ST_LENBYTE;
        default:   error_next = first_error;
      endcase
    end
  end

  always_comb begin
    if (byte_position != LAST_POS) begin
      status = ST_LENGTH;
    end else if (error_next != ST_OK) begin
      status = error_next;
    end else if (running_xor != in_byte) begin
      status = ST_CHECK;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.timestamp   = captured_time;
      res.frame_id    = captured_id;
      res.length_code = captured_dlc;
      res.frame_flags = captured_flags;
      res.frame_data  = captured_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      running_xor      <= '0;
      first_error      <= ST_OK;
      captured_time    <= '0;
      captured_id      <= '0;
      captured_dlc     <= '0;
      captured_flags   <= '0;
      captured_payload <= '0;
    end else if (in_take) begin
      if (in_last) begin
        byte_position    <= '0;
        running_xor      <= '0;
        first_error      <= ST_OK;
        captured_time    <= '0;
        captured_id      <= '0;
        captured_dlc     <= '0;
        captured_flags   <= '0;
        captured_payload <= '0;
      end else begin
        first_error <= error_next;
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + POS_W'(1);
        end
        if (byte_position >= POS_W'(2) && byte_position <= XOR_END) begin
          running_xor <= running_xor ^ in_byte;
        end
        // Timestamp at bytes 4..7, identifier at 8..11, little-endian.
        if (byte_position[5:2] == 4'd1) begin
          captured_time[8*byte_position[1:0] +: 8] <= in_byte;
        end
        if (byte_position[5:2] == 4'd2) begin
          captured_id[8*byte_position[1:0] +: 8] <= in_byte;
        end
        if (byte_position == POS_W'(12)) begin
          captured_dlc <= in_byte;
        end
        if (byte_position == POS_W'(13)) begin
          captured_flags <= in_byte;
        end
        if (byte_position >= POS_W'(14) && byte_position < DATA_END) begin
          captured_payload[8*data_offset[2:0] +: 8] <= in_byte;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/cfpd_out_slice.sv @@
// Result register driving the master stream.
`default_nettype none
module cfpd_out_slice
  import cfpd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire result_t                res,
  output logic                        load_ready,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  result_t res_q;

  assign load_ready = !m_tvalid || m_tready;
  assign m_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, res_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_ready) begin
      m_tvalid <= load;
    end
    if (load) begin
      res_q <= res;
    end
  end

endmodule
`default_nettype wire
